// File: design/sfr_pkg.sv
// Shared constants for the STX frame receiver: field widths, framing
// characters, frame layout and result status codes. No dependencies.
package sfr_pkg;

   // Payload buffer and field widths
   localparam int unsigned SFR_MAX_PAYLOAD = 64;
   localparam int unsigned SFR_ADDR_W      = $clog2(SFR_MAX_PAYLOAD);
   localparam int unsigned SFR_LEN_W       = $clog2(SFR_MAX_PAYLOAD + 1);
   localparam int unsigned SFR_COUNT_W     = 7;
   localparam int unsigned SFR_STATUS_W    = 2;

   // Frame layout: payload starts after seven header bytes, then two
   // checksum bytes and four trailer bytes follow.
   localparam int unsigned SFR_HDR_LEN     = 7;
   localparam int unsigned SFR_TRAILER_LEN = 4;

   // Framing characters
   localparam logic [7:0] SFR_CHAR_S     = 8'h53;
   localparam logic [7:0] SFR_CHAR_T     = 8'h54;
   localparam logic [7:0] SFR_CHAR_X     = 8'h58;
   localparam logic [7:0] SFR_CHAR_COMMA = 8'h2C;

   // Result status codes
   localparam logic [SFR_STATUS_W-1:0] SFR_ST_PAYLOAD = 2'd0;
   localparam logic [SFR_STATUS_W-1:0] SFR_ST_EMPTY   = 2'd1;
   localparam logic [SFR_STATUS_W-1:0] SFR_ST_BADSUM  = 2'd2;
   localparam logic [SFR_STATUS_W-1:0] SFR_ST_TOOLONG = 2'd3;

endpackage

// File: design/sfr_req_if.sv
// Input byte channel of the STX frame receiver: valid/ready plus one link byte.
// Depends on sfr_pkg.
interface sfr_req_if;
   import sfr_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/sfr_rsp_if.sv
// Result channel of the STX frame receiver: valid/ready plus one result item.
// Depends on sfr_pkg.
interface sfr_rsp_if;
   import sfr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SFR_STATUS_W-1:0] status;
   logic [7:0]              frame_type;
   logic [SFR_LEN_W-1:0]    frame_length;
   logic [7:0]              data_byte;
   logic [SFR_ADDR_W-1:0]   byte_index;
   logic                    last;

   modport source (output valid, output status, output frame_type, output frame_length,
                   output data_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input status, input frame_type, input frame_length,
                   input data_byte, input byte_index, input last, output ready);
endinterface

// File: design/stx_frame_receiver.sv
// STX frame receiver top level: header parse, checksum and payload drain.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if and sfr_ram.
//
//   channel   direction  transaction
//   req_bus   in         one link byte (rx_byte)
//   rsp_bus   out        one result item (status, type, length, data, index, last)
//
// Flow: link bytes are taken while a frame is being parsed. A good
// frame with L > 0 payload bytes then drains one result item at a time
// through the payload RAM's single read port: read, then load the output
// register once rsp_bus has taken any item it still holds.
// Reset: synchronous, active high; clears the parser and drain control.
// The payload RAM has no clearing pass: only entries the current frame
// wrote are ever read back.
// Stalls: req_bus.ready drops during a drain and while the output register
// holds an item that rsp_bus has not taken.
module stx_frame_receiver (
   input logic        clock,
   input logic        reset,
   sfr_req_if.sink    req_bus,
   sfr_rsp_if.source  rsp_bus
);
   import sfr_pkg::*;

   // Control states
   localparam logic [1:0] FSM_RUN  = 2'd0;   // take link bytes
   localparam logic [1:0] FSM_READ = 2'd1;   // issue a payload RAM read
   localparam logic [1:0] FSM_LOAD = 2'd2;   // move read data into the output register

   logic [1:0]             state_ff, state_in;
   logic [SFR_COUNT_W-1:0] count_ff, count_in;
   logic                   hdr_bad_ff, hdr_bad_in;
   logic [7:0]             type_ff, type_in;
   logic [7:0]             len_hi_ff, len_hi_in;
   logic [SFR_LEN_W-1:0]   len_ff, len_in;
   logic [15:0]            sum_ff, sum_in;
   logic [15:0]            cksum_ff, cksum_in;
   logic [SFR_ADDR_W-1:0]  idx_ff, idx_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SFR_STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SFR_LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;
   logic [SFR_ADDR_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    load;

   logic        out_free;
   logic        req_fire;
   logic [7:0]  rx;
   logic [7:0]  pos;
   logic [7:0]  pay_end;
   logic [7:0]  want;
   logic        drain_last;
   logic [SFR_COUNT_W-1:0] pay_off;

   // Payload RAM ports
   logic                  wr_en;
   logic [SFR_ADDR_W-1:0] wr_addr;
   logic                  rd_en;
   logic [7:0]            rd_data;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == FSM_RUN) && out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rx            = req_bus.rx_byte;

   // Frame positions in 8 bits so the last trailer position cannot wrap
   assign pos     = {1'b0, count_ff};
   assign pay_end = 8'(SFR_HDR_LEN) + 8'(len_ff);
   assign pay_off = count_ff - SFR_COUNT_W'(SFR_HDR_LEN);
   assign wr_addr = pay_off[SFR_ADDR_W-1:0];

   assign drain_last = (SFR_LEN_W'(idx_ff) + SFR_LEN_W'(1)) == len_ff;

   always_comb begin
      case (count_ff[1:0])
         2'd1:    want = SFR_CHAR_T;
         2'd2:    want = SFR_CHAR_X;
         default: want = SFR_CHAR_COMMA;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hdr_bad_in   = hdr_bad_ff;
      type_in      = type_ff;
      len_hi_in    = len_hi_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      cksum_in     = cksum_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      load         = 1'b0;
      rsp_status_in = SFR_ST_PAYLOAD;
      rsp_len_in   = '0;
      rsp_data_in  = '0;
      rsp_idx_in   = '0;
      rsp_last_in  = 1'b1;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         FSM_RUN: begin
            if (req_fire) begin
               if (count_ff == '0) begin
                  // Hunt: drop everything but the start character
                  if (rx == SFR_CHAR_S) begin
                     count_in   = SFR_COUNT_W'(1);
                     hdr_bad_in = 1'b0;
                     sum_in     = '0;
                     cksum_in   = '0;
                  end
               end else if (count_ff <= SFR_COUNT_W'(3)) begin
                  if (rx != want) begin
                     hdr_bad_in = 1'b1;
                  end
                  count_in = count_ff + SFR_COUNT_W'(1);
               end else if (count_ff == SFR_COUNT_W'(4)) begin
                  type_in  = rx;
                  count_in = SFR_COUNT_W'(5);
               end else if (count_ff == SFR_COUNT_W'(5)) begin
                  // Length high byte; a bad header discards the frame here
                  len_hi_in = rx;
                  count_in  = hdr_bad_ff ? '0 : SFR_COUNT_W'(6);
               end else if (count_ff == SFR_COUNT_W'(6)) begin
                  if ({len_hi_ff, rx} > 16'(SFR_MAX_PAYLOAD)) begin
                     count_in      = '0;
                     load          = 1'b1;
                     rsp_status_in = SFR_ST_TOOLONG;
                  end else begin
                     len_in   = rx[SFR_LEN_W-1:0];
                     count_in = SFR_COUNT_W'(SFR_HDR_LEN);
                  end
               end else if (pos < pay_end) begin
                  // Payload byte: buffer it and add it to the running sum
                  wr_en    = 1'b1;
                  sum_in   = sum_ff + {8'h00, rx};
                  count_in = count_ff + SFR_COUNT_W'(1);
               end else if (pos == pay_end) begin
                  cksum_in = {rx, 8'h00};
                  count_in = count_ff + SFR_COUNT_W'(1);
               end else if (pos == pay_end + 8'd1) begin
                  cksum_in = {cksum_ff[15:8], rx};
                  count_in = count_ff + SFR_COUNT_W'(1);
               end else if (pos < pay_end + 8'(1 + SFR_TRAILER_LEN)) begin
                  count_in = count_ff + SFR_COUNT_W'(1);
               end else begin
                  // Last trailer byte: frame complete
                  count_in = '0;
                  if (sum_ff != cksum_ff) begin
                     load          = 1'b1;
                     rsp_status_in = SFR_ST_BADSUM;
                     rsp_len_in    = len_ff;
                  end else if (len_ff == '0) begin
                     load          = 1'b1;
                     rsp_status_in = SFR_ST_EMPTY;
                  end else begin
                     state_in = FSM_READ;
                     idx_in   = '0;
                  end
               end
            end
         end
         FSM_READ: begin
            // All payload writes are done before a drain starts, so the
            // read never races a write to the same entry.
            rd_en    = 1'b1;
            state_in = FSM_LOAD;
         end
         FSM_LOAD: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = SFR_ST_PAYLOAD;
               rsp_len_in    = len_ff;
               rsp_data_in   = rd_data;
               rsp_idx_in    = idx_ff;
               rsp_last_in   = drain_last;
               idx_in        = idx_ff + SFR_ADDR_W'(1);
               state_in      = drain_last ? FSM_RUN : FSM_READ;
            end
         end
         default: begin
            state_in = FSM_RUN;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_RUN;
         count_ff     <= '0;
         hdr_bad_ff   <= 1'b0;
         type_ff      <= '0;
         len_hi_ff    <= '0;
         len_ff       <= '0;
         sum_ff       <= '0;
         cksum_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hdr_bad_ff   <= hdr_bad_in;
         type_ff      <= type_in;
         len_hi_ff    <= len_hi_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         cksum_ff     <= cksum_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload: load only when the register is free
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (SFR_MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.frame_type   = type_ff;
   assign rsp_bus.frame_length = rsp_len_ff;
   assign rsp_bus.data_byte    = rsp_data_ff;
   assign rsp_bus.byte_index   = rsp_idx_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // Frame position never passes the last trailer byte of a maximum frame
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SFR_COUNT_W'(SFR_HDR_LEN + 2 + SFR_TRAILER_LEN + SFR_MAX_PAYLOAD - 1))
      else $error("frame position out of range");

   // A drain only runs over a nonempty frame and stays inside it
   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_RUN) |-> (len_ff != '0) && (SFR_LEN_W'(idx_ff) < len_ff))
      else $error("drain index outside the frame");

   // A payload item is last exactly at the final byte of the frame
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == SFR_ST_PAYLOAD)) |->
      (rsp_last_ff == ((SFR_LEN_W'(rsp_idx_ff) + SFR_LEN_W'(1)) == rsp_len_ff)))
      else $error("last flag does not match byte index");

   // No new link byte is taken while a drain is in progress
   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FSM_RUN) |-> !wr_en && (count_ff == '0))
      else $error("link byte taken during drain");
endmodule

// File: design/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: verif/stx_frame_receiver_test.sv
// Self-checking testbench for stx_frame_receiver: drives link bytes, predicts
// the deframed result items and compares every result transaction.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if and the stx_frame_receiver RTL.
module stx_frame_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   // Run length and limits
   localparam int unsigned RANDOM_ITEMS = 350;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TAIL_CYCLES  = 2 * SFR_MAX_PAYLOAD + 32;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DIR_ROWS     = 28;

   // One result item as the rsp channel carries it
   typedef struct packed {
      logic [SFR_STATUS_W-1:0] status;
      logic [7:0]              frame_type;
      logic [SFR_LEN_W-1:0]    frame_length;
      logic [7:0]              data_byte;
      logic [SFR_ADDR_W-1:0]   byte_index;
      logic                    last;
   } frame_item_type;

   // One link byte to send; typed rows carry their expected result
   typedef struct {
      logic [7:0]     rx_byte;
      bit             typed;
      frame_item_type want;
   } link_row_type;

   // Directed row: byte, typed flag, expected status and type (last is 1,
   // length, data and index are 0 for every typed row here)
   typedef struct packed {
      logic [7:0]              rx_byte;
      logic                    typed;
      logic [SFR_STATUS_W-1:0] status;
      logic [7:0]              ftype;
   } dir_row_type;

   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // hunting: extremes of the byte are dropped with no frame open
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      // bad header: third byte wrong, discarded silently after length high
      '{SFR_CHAR_S, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_T, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h51, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_COMMA, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hA5, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      // length one above the maximum, top type value
      '{SFR_CHAR_S, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_T, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_X, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_COMMA, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h41, 1'b1, SFR_ST_TOOLONG, 8'hFF},
      // empty frame with a wrong checksum, type zero
      '{SFR_CHAR_S, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_T, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_X, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{SFR_CHAR_COMMA, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h00, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'h01, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b0, SFR_ST_PAYLOAD, 8'h00},
      '{8'hFF, 1'b1, SFR_ST_BADSUM, 8'h00}
   };

   logic clock;
   logic reset;

   sfr_req_if req_bus();
   sfr_rsp_if rsp_bus();

   stx_frame_receiver i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Deframer predictor state
   logic [SFR_COUNT_W-1:0] parse_count = '0;
   logic [7:0]             hdr_type    = '0;
   logic [15:0]            hdr_length  = '0;
   logic [15:0]            payload_sum = '0;
   logic [15:0]            wire_sum    = '0;
   bit                     hdr_bad     = 1'b0;
   logic [7:0]             payload_buf [SFR_MAX_PAYLOAD];

   link_row_type   link_stim [$];
   frame_item_type fresh_items [$];
   frame_item_type pending_items [$];

   int unsigned bytes_taken  = 0;
   int unsigned results_seen = 0;
   int unsigned errors       = 0;
   int unsigned cycle_count  = 0;
   int unsigned noise_bytes  = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};

   // Receiver hold-off and stall pattern
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   logic [15:0] stall_mask  = '1;
   logic [3:0]  stall_phase = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Advance the deframer by one link byte; leave the results it releases
   // in fresh_items.
   function automatic void deframe_byte(input logic [7:0] b);
      int unsigned    p;
      int unsigned    len;
      logic [7:0]     want_ch;
      frame_item_type it;
      p   = parse_count;
      len = hdr_length;
      fresh_items = {};
      it = '0;
      it.frame_type = hdr_type;
      it.last = 1'b1;
      if (p == 0) begin
         // hunt: only 'S' opens a frame
         if (b == SFR_CHAR_S) begin
            parse_count = SFR_COUNT_W'(1);
            hdr_bad     = 1'b0;
            hdr_length  = '0;
            payload_sum = '0;
            wire_sum    = '0;
         end
      end else if (p <= 3) begin
         case (p)
            1: want_ch = SFR_CHAR_T;
            2: want_ch = SFR_CHAR_X;
            default: want_ch = SFR_CHAR_COMMA;
         endcase
         if (b != want_ch) hdr_bad = 1'b1;
         parse_count = SFR_COUNT_W'(p + 1);
      end else if (p == 4) begin
         hdr_type    = b;
         parse_count = SFR_COUNT_W'(5);
      end else if (p == 5) begin
         // a bad header is dropped once the length high byte is in
         hdr_length  = {b, 8'h00};
         parse_count = hdr_bad ? '0 : SFR_COUNT_W'(6);
      end else if (p == 6) begin
         hdr_length[7:0] = b;
         if (hdr_length > SFR_MAX_PAYLOAD) begin
            parse_count = '0;
            it.status   = SFR_ST_TOOLONG;
            fresh_items.push_back(it);
         end else begin
            parse_count = SFR_COUNT_W'(7);
         end
      end else if (p < SFR_HDR_LEN + len) begin
         payload_buf[SFR_ADDR_W'(p - SFR_HDR_LEN)] = b;
         payload_sum = payload_sum + b;
         parse_count = SFR_COUNT_W'(p + 1);
      end else if (p == SFR_HDR_LEN + len) begin
         wire_sum    = {b, 8'h00};
         parse_count = SFR_COUNT_W'(p + 1);
      end else if (p == SFR_HDR_LEN + 1 + len) begin
         wire_sum[7:0] = b;
         parse_count   = SFR_COUNT_W'(p + 1);
      end else if (p < SFR_HDR_LEN + 1 + SFR_TRAILER_LEN + len) begin
         parse_count = SFR_COUNT_W'(p + 1);
      end else begin
         // last trailer byte closes the frame
         parse_count = '0;
         it.frame_length = SFR_LEN_W'(len);
         if (payload_sum != wire_sum) begin
            it.status = SFR_ST_BADSUM;
            fresh_items.push_back(it);
         end else if (len == 0) begin
            it.status = SFR_ST_EMPTY;
            fresh_items.push_back(it);
         end else begin
            for (int unsigned i = 0; i < len; i++) begin
               it.status     = SFR_ST_PAYLOAD;
               it.data_byte  = payload_buf[SFR_ADDR_W'(i)];
               it.byte_index = SFR_ADDR_W'(i);
               it.last       = (i + 1 == len);
               fresh_items.push_back(it);
            end
         end
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      link_row_type row;
      row.rx_byte = b;
      row.typed   = 1'b0;
      row.want    = '0;
      link_stim.push_back(row);
   endfunction

   // Queue a well-formed header with the given length; for a legal length
   // add random payload, its checksum (optionally corrupted) and trailer.
   function automatic void queue_frame(input logic [7:0] ftype, input int unsigned len,
                                       input bit corrupt);
      logic [15:0] sum;
      logic [7:0]  b;
      sum = '0;
      queue_byte(SFR_CHAR_S);
      queue_byte(SFR_CHAR_T);
      queue_byte(SFR_CHAR_X);
      queue_byte(SFR_CHAR_COMMA);
      queue_byte(ftype);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
      if (len > SFR_MAX_PAYLOAD) return;
      for (int unsigned i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         queue_byte(b);
      end
      if (corrupt) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
      queue_byte(sum[15:8]);
      queue_byte(sum[7:0]);
      for (int unsigned i = 0; i < SFR_TRAILER_LEN; i++) begin
         queue_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d: %s got 0x%0h, want 0x%0h",
                                   results_seen, name, got, want));
      end
   endtask

   // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_items.size());
         $display("stx_frame_receiver_test NOT OK");
         $finish;
      end
   end

   // Monitor: check the result transaction first, then predict from the
   // byte taken at the same edge (its results cannot appear this early).
   always @(posedge clock) begin
      frame_item_type want;
      link_row_type   row;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_items.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d: status %0d type 0x%0h len %0d",
                                         results_seen, rsp_bus.status, rsp_bus.frame_type,
                                         rsp_bus.frame_length));
            end else begin
               want = pending_items.pop_front();
               check_field("status", rsp_bus.status, want.status);
               check_field("frame_type", rsp_bus.frame_type, want.frame_type);
               check_field("frame_length", rsp_bus.frame_length, want.frame_length);
               check_field("data_byte", rsp_bus.data_byte, want.data_byte);
               check_field("byte_index", rsp_bus.byte_index, want.byte_index);
               check_field("last", rsp_bus.last, want.last);
               status_seen[want.status]++;
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            row = link_stim[bytes_taken];
            deframe_byte(req_bus.rx_byte);
            // typed rows carry their own expectation; the predictor still
            // advances so its state stays in step
            if (row.typed) pending_items.push_back(row.want);
            else foreach (fresh_items[i]) pending_items.push_back(fresh_items[i]);
            bytes_taken <= bytes_taken + 1;
         end
      end
   end

   // Receiver: one long hold-off early in the random part so the output
   // register fills and the input stalls, otherwise a stall pattern from a
   // 16-bit mask redrawn each period (some periods never stall).
   always @(posedge clock) begin
      int unsigned mode;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (!hold_done && bytes_taken > DIR_ROWS && rsp_bus.valid) begin
         rsp_bus.ready <= 1'b0;
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
      end else begin
         if (stall_phase == 4'd0) begin
            mode = $urandom_range(0, 3);
            if (mode == 0) stall_mask = '1;
            else if (mode == 1) stall_mask = 16'($urandom);
            else if (mode == 2) stall_mask = 16'($urandom | $urandom);
            else stall_mask = 16'($urandom & $urandom);
         end
         rsp_bus.ready <= stall_mask[stall_phase];
         stall_phase = stall_phase + 4'd1;
      end
   end

   // Stimulus build, reset, sender and end of run
   initial begin
      link_row_type row;
      int unsigned  kind;
      int unsigned  len;
      int unsigned  burst_left;
      int unsigned  gap;
      int unsigned  wrong_at;
      int unsigned  n;
      logic [7:0]   b;
      bit           max_done;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;

      // Walk the directed table
      foreach (DIRECTED[i]) begin
         row.rx_byte = DIRECTED[i].rx_byte;
         row.typed   = DIRECTED[i].typed;
         row.want    = '0;
         row.want.status     = DIRECTED[i].status;
         row.want.frame_type = DIRECTED[i].ftype;
         row.want.last       = 1'b1;
         link_stim.push_back(row);
      end

      // Random part: mostly well-formed frames, some broken ones and noise.
      // The first well-formed frame carries the largest payload.
      max_done = 1'b0;
      while (link_stim.size() - DIR_ROWS - noise_bytes < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            if (!max_done) len = SFR_MAX_PAYLOAD;
            else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, SFR_MAX_PAYLOAD);
            else len = $urandom_range(0, 8);
            max_done = 1'b1;
            queue_frame(8'($urandom_range(0, 255)), len, kind >= 60);
         end else if (kind < 80) begin
            // broken header: at least one of bytes 1 to 3 flipped
            wrong_at = $urandom_range(1, 3);
            queue_byte(SFR_CHAR_S);
            for (int unsigned k = 1; k <= 3; k++) begin
               b = (k == 1) ? SFR_CHAR_T : (k == 2) ? SFR_CHAR_X : SFR_CHAR_COMMA;
               if (k == wrong_at || $urandom_range(0, 3) == 0) b = b ^ 8'($urandom_range(1, 255));
               queue_byte(b);
            end
            queue_byte(8'($urandom_range(0, 255)));
            queue_byte(8'($urandom_range(0, 255)));
         end else if (kind < 88) begin
            if ($urandom_range(0, 1) == 0) len = $urandom_range(SFR_MAX_PAYLOAD + 1, 255);
            else len = $urandom_range(256, 16'hFFFF);
            queue_frame(8'($urandom_range(0, 255)), len, 1'b0);
         end else begin
            // line noise between frames; keep it from opening a frame
            n = $urandom_range(1, 4);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == SFR_CHAR_S) b = b ^ 8'h01;
               queue_byte(b);
            end
            noise_bytes += n;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Send in bursts with random gaps; hold each byte until taken
      burst_left = 0;
      foreach (link_stim[i]) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
         req_bus.valid   <= 1'b1;
         req_bus.rx_byte <= link_stim[i].rx_byte;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         burst_left--;
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);

      // Drain: wait for every expected result, then watch for strays
      while (pending_items.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d link bytes (%0d directed, %0d noise), %0d results checked",
               link_stim.size(), DIR_ROWS, noise_bytes, results_seen);
      $display("results: payload %0d, empty %0d, bad checksum %0d, too long %0d",
               status_seen[SFR_ST_PAYLOAD], status_seen[SFR_ST_EMPTY],
               status_seen[SFR_ST_BADSUM], status_seen[SFR_ST_TOOLONG]);
      if (errors == 0) begin
         $display("stx_frame_receiver_test OK");
      end else begin
         $display("stx_frame_receiver_test NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
design/sfr_pkg.sv
design/sfr_req_if.sv
design/sfr_rsp_if.sv
design/sfr_ram.sv
design/stx_frame_receiver.sv
verif/stx_frame_receiver_test.sv
